// ===== hw/rtl/alhc_pkg.sv =====
`default_nettype none

package alhc_pkg;

    localparam int LEVEL_W = 8;
    localparam int CONF_W  = 10;
    localparam int HOLD_W  = 14;
    localparam int PHASE_W = 3;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE     = 3'd0,
        PH_PARK_ON  = 3'd1,
        PH_BEAM_ON  = 3'd2,
        PH_BEAM_OFF = 3'd3,
        PH_PARK_OFF = 3'd4,
        PH_LOCK     = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        REG_PARK_ON   = 3'd0,
        REG_PARK_OFF  = 3'd1,
        REG_BEAM_ON   = 3'd2,
        REG_BEAM_OFF  = 3'd3,
        REG_ON_COUNT  = 3'd4,
        REG_OFF_COUNT = 3'd5,
        REG_HOLD      = 3'd6
    } t_reg_idx;

    localparam logic [LEVEL_W-1:0] RST_PARK_ON   = 8'd150;
    localparam logic [LEVEL_W-1:0] RST_PARK_OFF  = 8'd48;
    localparam logic [LEVEL_W-1:0] RST_BEAM_ON   = 8'd200;
    localparam logic [LEVEL_W-1:0] RST_BEAM_OFF  = 8'd50;
    localparam logic [CONF_W-1:0]  RST_ON_COUNT  = 10'd236;
    localparam logic [CONF_W-1:0]  RST_OFF_COUNT = 10'd436;
    localparam logic [HOLD_W-1:0]  RST_HOLD      = 14'd10001;

    localparam logic [LEVEL_W-1:0] GUARD_PARK_ON  = 8'd140;
    localparam logic [LEVEL_W-1:0] GUARD_BEAM_ON  = 8'd190;
    localparam logic [LEVEL_W-1:0] GUARD_BEAM_OFF = 8'd60;
    localparam logic [LEVEL_W-1:0] GUARD_PARK_OFF = 8'd48;

endpackage

`default_nettype wire

// ===== hw/rtl/alhc_in_if.sv =====
`default_nettype none

interface alhc_in_if;
    logic                          valid;
    logic                          ready;
    logic [alhc_pkg::LEVEL_W-1:0]  light_level;
    logic                          ignition_on;
    logic                          lock_request;

    modport source (output valid, output light_level, output ignition_on,
                    output lock_request, input ready);
    modport sink   (input valid, input light_level, input ignition_on,
                    input lock_request, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/alhc_out_if.sv =====
`default_nettype none

interface alhc_out_if;
    logic                          valid;
    logic                          ready;
    logic                          park_light;
    logic                          low_beam;
    logic [alhc_pkg::PHASE_W-1:0]  phase;

    modport source (output valid, output park_light, output low_beam,
                    output phase, input ready);
    modport sink   (input valid, input park_light, input low_beam,
                    input phase, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/auto_light_hysteresis_controller.sv =====
// Automatic lamp controller. Each sample transfer (darkness level, ignition,
// lock button) yields exactly one result transfer with the lamp drives and the
// current phase after that sample. A sample is registered, evaluated by one
// pass of compare and count logic and written to the result register. One
// sample is taken per clock while results are accepted; a stalled output
// holds both registers, so a sample is taken only into an empty input stage.
// The user must write thresholds and counts over the APB port only while no
// sample is in flight; the block does not enforce it. pready is always high.
`default_nettype none

module auto_light_hysteresis_controller #(
    parameter int COUNT_BITS = 14
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    alhc_in_if.sink                         i_sample,
    alhc_out_if.source                      o_result,
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire [alhc_pkg::ADDR_W-1:0]      paddr,
    input  wire [alhc_pkg::DATA_W-1:0]      pwdata,
    output logic [alhc_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);
    import alhc_pkg::*;

    localparam int CMP_W = (COUNT_BITS > HOLD_W) ? COUNT_BITS : HOLD_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // configuration
    logic [LEVEL_W-1:0] r_park_on, r_park_off, r_beam_on, r_beam_off;
    logic [CONF_W-1:0]  r_on_cnt, r_off_cnt;
    logic [HOLD_W-1:0]  r_hold;

    // input stage
    logic               r_in_valid;
    logic [LEVEL_W-1:0] r_in_level;
    logic               r_in_ign;
    logic               r_in_lock;

    // state
    t_phase                r_phase, n_phase;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  r_park, n_park;
    logic                  r_beam, n_beam;

    // result stage
    logic               r_out_valid;
    logic               r_out_park;
    logic               r_out_beam;
    logic [PHASE_W-1:0] r_out_phase;

    logic                  advance;
    logic                  step;
    logic                  wr_en;
    logic [CONF_W-1:0]     on_n, off_n;
    logic [HOLD_W-1:0]     hold_n;
    logic                  guard_ok;
    logic [HOLD_W-1:0]     run_target;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic                  run_done;
    logic                  hold_done;

    assign advance        = !r_out_valid || o_result.ready;
    assign step           = r_in_valid && advance;
    assign i_sample.ready = !r_in_valid || advance;

    assign o_result.valid      = r_out_valid;
    assign o_result.park_light = r_out_park;
    assign o_result.low_beam   = r_out_beam;
    assign o_result.phase      = r_out_phase;

    // APB
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        case (paddr[4:2])
            REG_PARK_ON:   prdata = DATA_W'(r_park_on);
            REG_PARK_OFF:  prdata = DATA_W'(r_park_off);
            REG_BEAM_ON:   prdata = DATA_W'(r_beam_on);
            REG_BEAM_OFF:  prdata = DATA_W'(r_beam_off);
            REG_ON_COUNT:  prdata = DATA_W'(r_on_cnt);
            REG_OFF_COUNT: prdata = DATA_W'(r_off_cnt);
            REG_HOLD:      prdata = DATA_W'(r_hold);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_park_on  <= RST_PARK_ON;
            r_park_off <= RST_PARK_OFF;
            r_beam_on  <= RST_BEAM_ON;
            r_beam_off <= RST_BEAM_OFF;
            r_on_cnt   <= RST_ON_COUNT;
            r_off_cnt  <= RST_OFF_COUNT;
            r_hold     <= RST_HOLD;
        end else if (wr_en) begin
            case (paddr[4:2])
                REG_PARK_ON:   r_park_on  <= pwdata[LEVEL_W-1:0];
                REG_PARK_OFF:  r_park_off <= pwdata[LEVEL_W-1:0];
                REG_BEAM_ON:   r_beam_on  <= pwdata[LEVEL_W-1:0];
                REG_BEAM_OFF:  r_beam_off <= pwdata[LEVEL_W-1:0];
                REG_ON_COUNT:  r_on_cnt   <= pwdata[CONF_W-1:0];
                REG_OFF_COUNT: r_off_cnt  <= pwdata[CONF_W-1:0];
                REG_HOLD:      r_hold     <= pwdata[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // zero counts act as one
    assign on_n   = (r_on_cnt == '0) ? CONF_W'(1) : r_on_cnt;
    assign off_n  = (r_off_cnt == '0) ? CONF_W'(1) : r_off_cnt;
    assign hold_n = (r_hold == '0) ? HOLD_W'(1) : r_hold;

    assign cnt_inc = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;

    always_comb begin
        guard_ok   = 1'b0;
        run_target = HOLD_W'(on_n);
        case (r_phase)
            PH_PARK_ON: begin
                guard_ok   = r_in_level >= GUARD_PARK_ON;
                run_target = HOLD_W'(on_n);
            end
            PH_BEAM_ON: begin
                guard_ok   = r_in_level >= GUARD_BEAM_ON;
                run_target = HOLD_W'(on_n);
            end
            PH_BEAM_OFF: begin
                guard_ok   = r_in_level <= GUARD_BEAM_OFF;
                run_target = HOLD_W'(off_n);
            end
            PH_PARK_OFF: begin
                guard_ok   = r_in_level <= GUARD_PARK_OFF;
                run_target = HOLD_W'(off_n);
            end
            default: begin
                guard_ok   = 1'b0;
                run_target = HOLD_W'(on_n);
            end
        endcase
    end

    assign run_done  = (CMP_W'(cnt_inc) >= CMP_W'(run_target)) || (cnt_inc == COUNT_MAX);
    assign hold_done = (CMP_W'(cnt_inc) >= CMP_W'(hold_n)) || (cnt_inc == COUNT_MAX);

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_park  = r_park;
        n_beam  = r_beam;
        case (r_phase)
            PH_PARK_ON, PH_BEAM_ON, PH_BEAM_OFF, PH_PARK_OFF: begin
                if (!r_in_ign || !guard_ok) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_count = cnt_inc;
                    if (run_done) begin
                        n_phase = PH_IDLE;
                        case (r_phase)
                            PH_PARK_ON: begin
                                if (r_in_level > r_beam_on) n_beam = 1'b1;
                                if (r_in_level > r_park_on) n_park = 1'b1;
                            end
                            PH_BEAM_ON: begin
                                if (r_in_level > r_beam_on) n_beam = 1'b1;
                            end
                            PH_BEAM_OFF: begin
                                if (r_in_level < r_beam_off) n_beam = 1'b0;
                            end
                            default: begin
                                if (r_in_level < r_park_off) n_park = 1'b0;
                            end
                        endcase
                    end
                end
            end
            PH_LOCK: begin
                if (r_in_ign) begin
                    n_park  = 1'b0;
                    n_beam  = 1'b0;
                    n_phase = PH_IDLE;
                end else begin
                    n_count = cnt_inc;
                    if (hold_done) begin
                        n_park  = 1'b0;
                        n_beam  = 1'b0;
                        n_phase = PH_IDLE;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (r_in_ign) begin
                    n_count = '0;
                    if (r_in_level > r_park_on && !r_park) begin
                        n_phase = PH_PARK_ON;
                    end else if (r_in_level > r_beam_on && !r_beam) begin
                        n_phase = PH_BEAM_ON;
                    end else if (r_in_level < r_beam_off && r_beam) begin
                        n_phase = PH_BEAM_OFF;
                    end else if (r_in_level < r_park_off && r_park) begin
                        n_phase = PH_PARK_OFF;
                    end
                end else if (r_in_lock && r_in_level > r_park_on) begin
                    n_park  = 1'b1;
                    n_beam  = 1'b1;
                    n_phase = PH_LOCK;
                    n_count = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_count     <= '0;
            r_park      <= 1'b0;
            r_beam      <= 1'b0;
        end else begin
            if (i_sample.ready) begin
                r_in_valid <= i_sample.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (step) begin
                r_phase <= n_phase;
                r_count <= n_count;
                r_park  <= n_park;
                r_beam  <= n_beam;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.valid && i_sample.ready) begin
            r_in_level <= i_sample.light_level;
            r_in_ign   <= i_sample.ignition_on;
            r_in_lock  <= i_sample.lock_request;
        end
        if (step) begin
            r_out_park  <= n_park;
            r_out_beam  <= n_beam;
            r_out_phase <= n_phase;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/alhc_checker.sv =====
`default_nettype none

module alhc_checker (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           i_out_valid,
    input wire                           i_out_ready,
    input wire                           i_park_light,
    input wire                           i_low_beam,
    input wire [alhc_pkg::PHASE_W-1:0]   i_phase
);
    import alhc_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_park_light) && $stable(i_low_beam) && $stable(i_phase))
        else $error("result changed while stalled");

    a_lock_lamps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_phase == PH_LOCK |-> i_park_light && i_low_beam)
        else $error("lock hold without both lamps lit");

    a_run_lamps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            !(i_phase == PH_PARK_ON && i_park_light) &&
            !(i_phase == PH_BEAM_ON && i_low_beam) &&
            !(i_phase == PH_BEAM_OFF && !i_low_beam) &&
            !(i_phase == PH_PARK_OFF && !i_park_light))
        else $error("qualification run does not match lamp state");

    a_reset_quiet: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind auto_light_hysteresis_controller alhc_checker u_alhc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_park_light (o_result.park_light),
    .i_low_beam   (o_result.low_beam),
    .i_phase      (o_result.phase)
);

`default_nettype wire
